// ===== hdl/rgb_to_hue_core_defines.svh =====
// assertion macros for the rgb to hue core
`ifndef RGB_TO_HUE_CORE_DEFINES_SVH
`define RGB_TO_HUE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RTH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_to_hue_core check failed");

// next-cycle implication, sampled on clk, off during reset
`define RTH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_to_hue_core check failed");

`endif

// ===== hdl/rth_pkg.sv =====
`default_nettype none

package rth_pkg;

	localparam int CH_W           = 8;
	localparam int HUE_W          = 9;
	localparam int NUM_W          = 17;
	localparam int BITS_PER_STAGE = 3;
	localparam int DIV_STAGES     = 3;
	localparam int PIPE_DEPTH     = 2 + DIV_STAGES;

	localparam logic [HUE_W-1:0] COEF_WRAP  = HUE_W'(360);
	localparam logic [HUE_W-1:0] COEF_GREEN = HUE_W'(120);
	localparam logic [HUE_W-1:0] COEF_BLUE  = HUE_W'(240);
	localparam int               HUE_STEP   = 60;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// max/min result, diff is two's complement
	typedef struct packed {
		logic            gray;
		logic [CH_W-1:0] delta;
		sector_t         sector;
		logic [CH_W:0]   diff;
	} prep_t;

	// running division state
	typedef struct packed {
		logic             gray;
		logic [CH_W-1:0]  delta;
		logic [NUM_W-1:0] rem;
		logic [HUE_W-1:0] quo;
	} div_t;

	typedef logic [PIPE_DEPTH-1:0] stage_mask_t;

endpackage

`default_nettype wire

// ===== hdl/rth_prep.sv =====
`default_nettype none

module rth_prep import rth_pkg::*; (
	input  wire logic            clk,
	input  wire logic [CH_W-1:0] red,
	input  wire logic [CH_W-1:0] green,
	input  wire logic [CH_W-1:0] blue,
	input  wire logic            adv_s1,
	input  wire logic            adv_s2,
	output div_t                 num_s2
);

	localparam logic signed [NUM_W+1:0] SIXTY = (NUM_W+2)'(HUE_STEP);

	prep_t                    prep_d;
	prep_t                    prep_s1;
	logic [CH_W-1:0]          hi;
	logic [CH_W-1:0]          lo;
	logic [HUE_W-1:0]         coef;
	logic [NUM_W-1:0]         base_prod;
	logic signed [NUM_W+1:0]  off;
	logic signed [NUM_W+1:0]  sum;
	div_t                     num_d;

	// stage 1: max, min, sector and channel difference
	always_comb begin
		lo = red;
		if (green < lo) begin
			lo = green;
		end
		if (blue < lo) begin
			lo = blue;
		end
		if (red >= green && red >= blue) begin
			hi            = red;
			prep_d.sector = SECT_RED;
			prep_d.diff   = {1'b0, green} - {1'b0, blue};
		end else if (green >= blue) begin
			hi            = green;
			prep_d.sector = SECT_GREEN;
			prep_d.diff   = {1'b0, blue} - {1'b0, red};
		end else begin
			hi            = blue;
			prep_d.sector = SECT_BLUE;
			prep_d.diff   = {1'b0, red} - {1'b0, green};
		end
		prep_d.delta = hi - lo;
		prep_d.gray  = (prep_d.delta == '0);
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			prep_s1 <= prep_d;
		end
	end

	// stage 2: numerator over delta, always in [0, 360*delta)
	always_comb begin
		case (prep_s1.sector)
			SECT_RED:   coef = prep_s1.diff[CH_W] ? COEF_WRAP : '0;
			SECT_GREEN: coef = COEF_GREEN;
			SECT_BLUE:  coef = COEF_BLUE;
			default:    coef = '0;
		endcase
		base_prod   = NUM_W'(coef) * NUM_W'(prep_s1.delta);
		off         = (NUM_W+2)'(signed'(prep_s1.diff)) * SIXTY;
		sum         = signed'({2'b00, base_prod}) + off;
		num_d.gray  = prep_s1.gray;
		num_d.delta = prep_s1.delta;
		num_d.rem   = sum[NUM_W-1:0];
		num_d.quo   = '0;
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			num_s2 <= num_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rth_divider.sv =====
`default_nettype none

module rth_divider import rth_pkg::*; (
	input  wire logic             clk,
	input  wire div_t             num_s2,
	input  wire logic             adv_s3,
	input  wire logic             adv_s4,
	input  wire logic             adv_s5,
	output logic [HUE_W-1:0]      hue
);

	localparam int TOP_S3 = HUE_W - 1;
	localparam int TOP_S4 = TOP_S3 - BITS_PER_STAGE;
	localparam int TOP_S5 = TOP_S4 - BITS_PER_STAGE;

	div_t div_s3;
	div_t div_s4;
	div_t div_s5;

	// restoring division, a few quotient bits per stage
	function automatic div_t div_step(input div_t cur, input int top_bit);
		div_t             res;
		logic [NUM_W-1:0] trial;
		int               sh;
		res = cur;
		for (int j = 0; j < BITS_PER_STAGE; j++) begin
			sh    = top_bit - j;
			trial = NUM_W'(res.delta) << sh;
			if (res.rem >= trial) begin
				res.rem = res.rem - trial;
				res.quo = res.quo | (HUE_W'(1) << sh);
			end
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			div_s3 <= div_step(num_s2, TOP_S3);
		end
		if (adv_s4) begin
			div_s4 <= div_step(div_s3, TOP_S4);
		end
		if (adv_s5) begin
			div_s5 <= div_step(div_s4, TOP_S5);
		end
	end

	assign hue = div_s5.gray ? '0 : div_s5.quo;

endmodule

`default_nettype wire

// ===== hdl/rgb_to_hue_core.sv =====
// channel  direction  handshake           payload
// in       to core    in_valid/in_stall   red, green, blue (8 bits each)
// out      from core  out_valid/out_stall hue_degrees (9 bits, 0..359)
//
// five register stages: max/min, numerator, then three divider stages
// of three quotient bits each; one pixel per cycle while the output is not stalled
// the divider stage depth sets the clock limit
// reset clears the stage valid bits only
// a stalled output holds; bubbles close up before in_stall rises
`default_nettype none

module rgb_to_hue_core import rth_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CH_W-1:0]   red,
	input  wire logic [CH_W-1:0]   green,
	input  wire logic [CH_W-1:0]   blue,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [HUE_W-1:0]       hue_degrees
);

	stage_mask_t vld_q;
	stage_mask_t adv;
	div_t        num_s2;

	always_comb begin
		adv[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || !out_stall;
		for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < PIPE_DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[PIPE_DEPTH-1];

	rth_prep u_prep (
		.clk    (clk),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.adv_s1 (adv[0]),
		.adv_s2 (adv[1]),
		.num_s2 (num_s2)
	);

	rth_divider u_div (
		.clk    (clk),
		.num_s2 (num_s2),
		.adv_s3 (adv[2]),
		.adv_s4 (adv[3]),
		.adv_s5 (adv[4]),
		.hue    (hue_degrees)
	);

endmodule

`default_nettype wire

// ===== hdl/rth_checker.sv =====
`default_nettype none

`include "rgb_to_hue_core_defines.svh"

module rth_checker import rth_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic [CH_W-1:0]  red,
	input wire logic [CH_W-1:0]  green,
	input wire logic [CH_W-1:0]  blue,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [HUE_W-1:0] hue_degrees
);

	// hue stays below a full turn
	`RTH_ASSERT_IMP(a_hue_range, out_valid, hue_degrees < HUE_W'(360))

	// a stalled output transaction holds its hue
	`RTH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hue_degrees))

	// input only stalls when the pipe is full and the output is blocked
	`RTH_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

	// a gray pixel comes out as zero when the output does not stall on its way through
	`RTH_ASSERT_NXT(a_gray_zero, in_valid && !in_stall && red == green && green == blue ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid && hue_degrees == '0)

endmodule

bind rgb_to_hue_core rth_checker u_chk (.*);

`default_nettype wire

// ===== sim/rgb_to_hue_checker.sv =====
`timescale 1ns / 100ps

module rgb_to_hue_checker import rth_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [CH_W-1:0]   red,
	input  logic [CH_W-1:0]   green,
	input  logic [CH_W-1:0]   blue,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [HUE_W-1:0]  hue_degrees,
	output int                fail_count,
	output int                pending
);

	logic [HUE_W-1:0] hue_q[$];

	// floor of the exact hue, red wins ties, then green
	function automatic logic [HUE_W-1:0] predict_hue(input logic [CH_W-1:0] r,
		input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int hi;
		int lo;
		int delta;
		int num;
		hi = int'(r);
		if (int'(g) > hi) hi = int'(g);
		if (int'(b) > hi) hi = int'(b);
		lo = int'(r);
		if (int'(g) < lo) lo = int'(g);
		if (int'(b) < lo) lo = int'(b);
		delta = hi - lo;
		if (delta == 0)
			return '0;
		if (r >= g && r >= b) begin
			num = 60 * (int'(g) - int'(b));
			if (num < 0) num += 360 * delta;
		end else if (g >= b) begin
			num = 120 * delta + 60 * (int'(b) - int'(r));
		end else begin
			num = 240 * delta + 60 * (int'(r) - int'(g));
		end
		return HUE_W'(num / delta);
	endfunction

	always @(posedge clk) begin
		logic [HUE_W-1:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (hue_q.size() == 0) begin
					$display("%0t: hue expected none actual %0d", $time, hue_degrees);
					fail_count++;
				end else begin
					want = hue_q.pop_front();
					if (hue_degrees !== want) begin
						$display("%0t: hue expected %0d actual %0d", $time, want,
							hue_degrees);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				hue_q.push_back(predict_hue(red, green, blue));
			pending = hue_q.size();
		end
	end

endmodule

// ===== sim/rgb_to_hue_core_tb.sv =====
`timescale 1ns / 100ps

module rgb_to_hue_core_tb import rth_pkg::*;;

	localparam int RANDOM_PIXELS = 1200;
	localparam int STALL_LIMIT   = 2000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [HUE_W-1:0]  hue_degrees;
	int                fail_count;
	int                pending;
	bit                gaps_on = 1'b1;
	int                quiet_cycles = 0;

	logic [3*CH_W-1:0] corner_px[24] = '{
		24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
		24'hffff00, 24'hff00ff, 24'h00ffff, 24'hff0001, 24'hff0100, 24'h010000,
		24'h000100, 24'h000001, 24'h010100, 24'hc86432, 24'h32c864, 24'h6432c8,
		24'h55aa00, 24'haa55ff, 24'h010203, 24'hfeff00, 24'h00feff, 24'h7f807f
	};

	rgb_to_hue_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hue_degrees (hue_degrees)
	);

	rgb_to_hue_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hue_degrees (hue_degrees),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= arst_n && gaps_on && ($urandom_range(99) < 33);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("rgb_to_hue_core_tb: errors");
				$finish;
			end
		end
	end

	// one transaction, called at a falling edge, returns at a falling edge
	task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] b);
		while (gaps_on && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		@(negedge clk);
	endtask

	// free pixels four times in ten, plus grays, ties, narrow spreads and extremes
	task automatic pick_pixel(output logic [CH_W-1:0] r, output logic [CH_W-1:0] g,
		output logic [CH_W-1:0] b);
		logic [CH_W-1:0] base;
		base = CH_W'($urandom);
		r = CH_W'($urandom);
		g = CH_W'($urandom);
		b = CH_W'($urandom);
		case ($urandom_range(9))
			0: begin
				g = r;
				b = r;
			end
			1: begin
				g = r;
			end
			2: begin
				b = ($urandom_range(1)) ? r : g;
			end
			3, 4: begin
				r = base ^ CH_W'($urandom_range(3));
				g = base ^ CH_W'($urandom_range(3));
				b = base ^ CH_W'($urandom_range(3));
			end
			5: begin
				r = ($urandom_range(1)) ? 8'hff : 8'h00;
				g = ($urandom_range(1)) ? 8'hff : CH_W'($urandom_range(2));
				b = ($urandom_range(1)) ? 8'h00 : CH_W'(255 - $urandom_range(2));
			end
			default: begin
			end
		endcase
	endtask

	initial begin
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		red       = '0;
		green     = '0;
		blue      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (corner_px[i])
			send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);
		drain_pipe();

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			gaps_on = !(i >= 500 && i < 800);
			if (i == 650)
				drain_pipe();
			pick_pixel(r, g, b);
			send_pixel(r, g, b);
		end
		gaps_on = 1'b1;

		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4 * PIPE_DEPTH) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("rgb_to_hue_core_tb: clean");
		else
			$display("rgb_to_hue_core_tb: errors");
		$finish;
	end

endmodule
